FILE: src/spe_pkg.sv
// Shared constants for the scan period estimator.
// No dependencies; used by scan_period_estimator_core, spe_period_checker and testbench.
package spe_pkg;

  localparam int PERIOD_W = 20;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W   = 5;

  localparam logic [PERIOD_W-1:0] PERIOD_LIMIT = 20'hFFFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd20000;

  localparam logic [COUNT_W-1:0]  PPU_RESET = 16'd1000;
  localparam logic [PERIOD_W-1:0] MIN_RESET = 20'd1000;
  localparam logic [PERIOD_W-1:0] MAX_RESET = 20'd60000;

  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_UPDATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD        = 2'd2;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PERIOD_W - 1);

endpackage

FILE: src/scan_period_estimator_core.sv
// Scan period estimator top level: pulse counter, radix-2 divider, clamp.
// Depends on spe_pkg.
//
// Each accepted pulse word yields one period_ms word. A pulse that does not
// trigger a recomputation passes through capture and clamp. Every
// pulses_per_update-th pulse passes through capture, difference, range
// check, 20 quotient bits from the shared compare/subtract unit and clamp;
// the divider yields one quotient bit per cycle. When the advance is zero
// or the quotient saturates, the divider is skipped.
// in_stall is high while a pulse is in work; the next pulse is taken as
// soon as the result sits in the output register, even if the downstream
// side still stalls it. A result that cannot enter the occupied output
// register holds the core until it does.
// Configuration writes are always ready and take effect at once.
module scan_period_estimator_core #(
  parameter int AZI_BITS  = 12,
  parameter int TIME_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [TIME_BITS-1:0]               time_ms,
  input  logic [AZI_BITS-1:0]                azimuth,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [spe_pkg::PERIOD_W-1:0]       period_ms,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spe_pkg::PERIOD_W-1:0]       cfg_data
);

  localparam int PW    = spe_pkg::PERIOD_W;
  localparam int SHIFT = PW - AZI_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_CLAMP = 3'd4;

  logic [2:0] state;

  logic [spe_pkg::COUNT_W-1:0] pulses_per_update;
  logic [PW-1:0]               min_period;
  logic [PW-1:0]               max_period;

  logic                        primed;
  logic [spe_pkg::COUNT_W-1:0] pulse_count;
  logic [TIME_BITS-1:0]        ref_time;
  logic [AZI_BITS-1:0]         ref_azimuth;
  logic [PW-1:0]               period_est;

  logic [TIME_BITS-1:0]        cur_time;
  logic [AZI_BITS-1:0]         cur_az;
  logic [TIME_BITS-1:0]        elapsed;
  logic [AZI_BITS-1:0]         advance;
  logic [AZI_BITS-1:0]         rem;
  logic [PW-1:0]               dbits;
  logic [PW-1:0]               quot;
  logic [spe_pkg::STEP_W-1:0]  step;

  logic                        accept;
  logic                        out_free;
  logic [spe_pkg::COUNT_W-1:0] count_next;
  logic [TIME_BITS-1:0]        elapsed_hi;
  logic                        saturate;
  logic [AZI_BITS:0]           trial;
  logic [AZI_BITS:0]           diff;
  logic                        take;
  logic [PW-1:0]               clamped;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign count_next = pulse_count + 1'b1;

  // elapsed * 2^AZI_BITS >= advance * 2^PW  <=>  (elapsed >> SHIFT) >= advance
  assign elapsed_hi = elapsed >> SHIFT;
  assign saturate   = (advance == '0) || (elapsed_hi >= TIME_BITS'(advance));

  // shared compare/subtract step of the divider
  assign trial = {rem, dbits[PW-1]};
  assign diff  = trial - {1'b0, advance};
  assign take  = (trial >= {1'b0, advance});

  always_comb begin
    clamped = period_est;
    if (clamped > max_period) begin
      clamped = max_period;
    end
    if (clamped < min_period) begin
      clamped = min_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_update <= spe_pkg::PPU_RESET;
      min_period        <= spe_pkg::MIN_RESET;
      max_period        <= spe_pkg::MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spe_pkg::REG_PULSES_PER_UPDATE: begin
          pulses_per_update <= cfg_data[spe_pkg::COUNT_W-1:0];
        end
        spe_pkg::REG_MIN_PERIOD: begin
          min_period <= cfg_data;
        end
        spe_pkg::REG_MAX_PERIOD: begin
          max_period <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_CLAMP && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      primed      <= 1'b0;
      pulse_count <= '0;
      ref_time    <= '0;
      ref_azimuth <= '0;
      period_est  <= spe_pkg::PERIOD_RESET;
      step        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!primed) begin
              ref_time    <= time_ms;
              ref_azimuth <= azimuth;
              primed      <= 1'b1;
            end
            if (count_next == pulses_per_update) begin
              pulse_count <= '0;
              state       <= S_DIFF;
            end else begin
              pulse_count <= count_next;
              state       <= S_CLAMP;
            end
          end
        end
        S_DIFF: begin
          ref_time    <= cur_time;
          ref_azimuth <= cur_az;
          state       <= S_CHECK;
        end
        S_CHECK: begin
          step <= '0;
          if (saturate) begin
            period_est <= spe_pkg::PERIOD_LIMIT;
            state      <= S_CLAMP;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == spe_pkg::LAST_STEP) begin
            period_est <= {quot[PW-2:0], take};
            state      <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          period_est <= clamped;
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_time <= time_ms;
      cur_az   <= azimuth;
    end
    if (state == S_DIFF) begin
      elapsed <= cur_time - ref_time;
      advance <= cur_az - ref_azimuth;
    end
    if (state == S_CHECK) begin
      rem   <= elapsed_hi[AZI_BITS-1:0];
      dbits <= {elapsed[SHIFT-1:0], {AZI_BITS{1'b0}}};
      quot  <= '0;
    end
    if (state == S_DIV) begin
      rem   <= take ? diff[AZI_BITS-1:0] : trial[AZI_BITS-1:0];
      dbits <= {dbits[PW-2:0], 1'b0};
      quot  <= {quot[PW-2:0], take};
    end
    if (state == S_CLAMP && out_free) begin
      period_ms <= clamped;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("core ready right after taking a pulse");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIFF) |-> (pulse_count == '0))
    else $error("pulse counter not cleared on recomputation");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (step <= spe_pkg::LAST_STEP))
    else $error("divider step counter out of range");

  a_min_clamp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (period_ms >= $past(min_period)))
    else $error("result below min_period");

  a_max_clamp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |->
      (period_ms <= $past(max_period) || period_ms == $past(min_period)))
    else $error("result above max_period");
`endif

endmodule

FILE: verif/spe_period_checker.sv
// Period checker for the scan period estimator: watches the pulse, period and
// register channels, predicts every period_ms word and compares in order.
// Depends on spe_pkg.
module spe_period_checker #(
  parameter int AZI_BITS  = 12,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [TIME_BITS-1:0]          time_ms,
  input  logic [AZI_BITS-1:0]           azimuth,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [spe_pkg::PERIOD_W-1:0]  period_ms,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [spe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spe_pkg::PERIOD_W-1:0]  cfg_data,
  output int                            fails,
  output int                            pending,
  output int                            periods_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = spe_pkg::PERIOD_W;
  localparam int CW = spe_pkg::COUNT_W;

  logic                 primed;
  logic [CW-1:0]        pulse_cnt;
  logic [TIME_BITS-1:0] ref_time;
  logic [AZI_BITS-1:0]  ref_az;
  logic [PW-1:0]        period_est;
  logic [CW-1:0]        pulses_per_update;
  logic [PW-1:0]        min_period;
  logic [PW-1:0]        max_period;
  logic [PW-1:0]        expected_periods[$];

  always @(posedge clk) begin : predict
    logic [TIME_BITS-1:0]          elapsed;
    logic [AZI_BITS-1:0]           advance;
    logic [TIME_BITS+AZI_BITS-1:0] quot;
    if (rst) begin
      primed            = 1'b0;
      pulse_cnt         = '0;
      ref_time          = '0;
      ref_az            = '0;
      period_est        = spe_pkg::PERIOD_RESET;
      pulses_per_update = spe_pkg::PPU_RESET;
      min_period        = spe_pkg::MIN_RESET;
      max_period        = spe_pkg::MAX_RESET;
      expected_periods.delete();
      fails           <= 0;
      pending         <= 0;
      periods_checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          spe_pkg::REG_PULSES_PER_UPDATE: pulses_per_update = cfg_data[CW-1:0];
          spe_pkg::REG_MIN_PERIOD:        min_period = cfg_data;
          spe_pkg::REG_MAX_PERIOD:        max_period = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (!primed) begin
          ref_time = time_ms;
          ref_az   = azimuth;
          primed   = 1'b1;
        end
        pulse_cnt = pulse_cnt + 1'b1;
        if (pulse_cnt == pulses_per_update) begin
          elapsed = time_ms - ref_time;
          advance = azimuth - ref_az;
          if (advance == '0) begin
            period_est = spe_pkg::PERIOD_LIMIT;
          end else begin
            quot = {elapsed, {AZI_BITS{1'b0}}} / advance;
            period_est = (quot > spe_pkg::PERIOD_LIMIT) ? spe_pkg::PERIOD_LIMIT
                                                        : quot[PW-1:0];
          end
          pulse_cnt = '0;
          ref_time  = time_ms;
          ref_az    = azimuth;
        end
        if (period_est > max_period) period_est = max_period;
        if (period_est < min_period) period_est = min_period;
        expected_periods.push_back(period_est);
      end
      if (out_valid && !out_stall) begin
        if (expected_periods.size() == 0) begin
          $error("period_ms: expected none, actual %0d", period_ms);
          fails <= fails + 1;
        end else begin
          if (period_ms !== expected_periods[0]) begin
            $error("period_ms: expected %0d, actual %0d", expected_periods[0], period_ms);
            fails <= fails + 1;
          end
          void'(expected_periods.pop_front());
          periods_checked <= periods_checked + 1;
        end
      end
      pending <= expected_periods.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// Top of the scan period estimator testbench: clock, reset, pulse and
// register stimulus, receiver stalls and the verdict.
// Depends on spe_pkg, scan_period_estimator_core and spe_period_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AZI_BITS    = 12;
  localparam int TIME_BITS   = 32;
  localparam int PERIOD_W    = spe_pkg::PERIOD_W;
  localparam int COUNT_W     = spe_pkg::COUNT_W;
  localparam int CFG_IDX_W   = spe_pkg::CFG_IDX_W;
  localparam int PHASE_WORDS = 163;
  localparam int DRAIN       = 40;
  localparam int LIMIT       = 200000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_BITS-1:0] time_ms = '0;
  logic [AZI_BITS-1:0]  azimuth = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PERIOD_W-1:0]  period_ms;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = spe_pkg::REG_PULSES_PER_UPDATE;
  logic [PERIOD_W-1:0]  cfg_data = '0;

  int fails, pending, periods_checked;
  int cycles = 0;
  int pulses_sent = 0;
  int settings = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  logic [TIME_BITS-1:0] cur_t;
  logic [AZI_BITS-1:0]  cur_az;
  int unsigned          scan_ms;

  scan_period_estimator_core #(.AZI_BITS(AZI_BITS), .TIME_BITS(TIME_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .time_ms(time_ms), .azimuth(azimuth),
    .out_valid(out_valid), .out_stall(out_stall), .period_ms(period_ms),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  spe_period_checker #(.AZI_BITS(AZI_BITS), .TIME_BITS(TIME_BITS)) period_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .time_ms(time_ms), .azimuth(azimuth),
    .out_valid(out_valid), .out_stall(out_stall), .period_ms(period_ms),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .periods_checked(periods_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_pulse(input logic [TIME_BITS-1:0] t, input logic [AZI_BITS-1:0] az);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    time_ms  <= t;
    azimuth  <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pulses_sent++;
  endtask

  // mostly a steadily turning antenna, with jumps and backward steps mixed in
  task automatic send_scan_pulse();
    int unsigned roll, dt;
    roll = $urandom_range(99);
    if (roll < 8) begin
      cur_t  = $urandom();
      cur_az = AZI_BITS'($urandom());
    end else if (roll < 12) begin
      cur_az = cur_az - AZI_BITS'($urandom_range(1, 300));
      cur_t  = cur_t + $urandom_range(0, 50);
    end else begin
      dt     = (roll < 14) ? 0 : $urandom_range(1, 40);
      cur_t  = cur_t + dt;
      cur_az = cur_az + AZI_BITS'((64'(dt) * 64'd4096) / scan_ms + $urandom_range(0, 2));
    end
    send_pulse(cur_t, cur_az);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [COUNT_W-1:0] ppu, input logic [PERIOD_W-1:0] lo,
                           input logic [PERIOD_W-1:0] hi);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_reg(spe_pkg::REG_PULSES_PER_UPDATE, PERIOD_W'(ppu));
    write_reg(spe_pkg::REG_MIN_PERIOD, lo);
    write_reg(spe_pkg::REG_MAX_PERIOD, hi);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    unique case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct <= 0;  end
      IDLE_SENDER:   begin send_idle_pct = 64; stall_pct <= 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct <= 64; end
      default:       begin send_idle_pct = 31; stall_pct <= 31; end
    endcase
  endtask

  initial begin
    logic [PERIOD_W-1:0] lo, hi;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_idling(IDLE_NONE);

    // directed: first pulse, advance/elapsed corners, wrap, saturation, clamps
    configure(16'd1, '0, spe_pkg::PERIOD_LIMIT);
    send_pulse(32'd100, 12'd0);
    send_pulse(32'd1100, 12'd1024);
    send_pulse(32'd1100, 12'd2048);
    send_pulse(32'd1600, 12'd1024);
    send_pulse(32'd1600, 12'd1024);
    send_pulse(32'hFFFF_FF00, 12'd1025);
    send_pulse(32'h0000_0100, 12'd2049);
    send_pulse(32'h0000_00FF, 12'd2050);
    send_pulse(32'hFFFF_FFFF, 12'd4095);
    send_pulse(32'd0, 12'd0);
    configure(16'd1, 20'd5000, 20'd3000);
    send_pulse(32'd10, 12'd5);
    send_pulse(32'd2000, 12'd1029);
    configure(16'd1, '0, '0);
    send_pulse(32'd3000, 12'd2053);
    configure(16'd1, spe_pkg::PERIOD_LIMIT, spe_pkg::PERIOD_LIMIT);
    send_pulse(32'd3001, 12'd2054);
    configure(16'd1, spe_pkg::MIN_RESET, spe_pkg::MAX_RESET);
    send_pulse(32'd900000, 12'd2055);
    send_pulse(32'd900001, 12'd2055 + 12'd2000);
    configure(16'd3, '0, spe_pkg::PERIOD_LIMIT);
    send_pulse(32'h8000_0000, 12'h800);
    send_pulse(32'h8000_1234, 12'hAAA);
    send_pulse(32'h8000_5678, 12'h555);

    cur_t  = $urandom();
    cur_az = AZI_BITS'($urandom());
    for (int ph = 0; ph < 8; ph++) begin
      unique case (ph % 4)
        0: begin lo = '0; hi = spe_pkg::PERIOD_LIMIT; end
        1: begin
          lo = PERIOD_W'($urandom_range(0, 30000));
          hi = PERIOD_W'($urandom_range(lo, 120000));
        end
        2: begin lo = PERIOD_W'($urandom()); hi = PERIOD_W'($urandom()); end
        default: begin lo = spe_pkg::MIN_RESET; hi = spe_pkg::MAX_RESET; end
      endcase
      configure(COUNT_W'($urandom_range(1, 12)), lo, hi);
      set_idling(idle_mode_e'(ph % 4));
      scan_ms = $urandom_range(200, 90000);
      repeat (PHASE_WORDS) send_scan_pulse();
    end

    // zero pulses_per_update with the counter already past it: no recompute
    set_idling(IDLE_NONE);
    configure('0, '0, spe_pkg::PERIOD_LIMIT);
    scan_ms = $urandom_range(1000, 20000);
    repeat (20) send_scan_pulse();
    configure(16'hFFFF, spe_pkg::MIN_RESET, spe_pkg::MAX_RESET);
    repeat (5) send_scan_pulse();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d pulse words, checked %0d periods over %0d register settings,",
             pulses_sent, periods_checked, settings);
    $display("all four idle patterns and a zero pulses_per_update setting.");
    if (fails == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
src/spe_pkg.sv
src/scan_period_estimator_core.sv
verif/spe_period_checker.sv
verif/testbench.sv
